### sv/elg_pkg.sv
package elg_pkg;

   localparam int WIDTH = 20;
   localparam int CNT_W = $clog2(WIDTH + 1);
   localparam int IDX_W = 2;

   localparam logic [IDX_W-1:0] REG_MODULUS     = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_GENERATOR   = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_PUBLIC_KEY  = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_PRIVATE_KEY = IDX_W'(3);

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // t is below 2*m: subtract m once if it fits
   function automatic logic [WIDTH-1:0] reduce_once(input logic [WIDTH:0] t,
                                                    input logic [WIDTH-1:0] m);
      logic [WIDTH:0] d;
      d = t - {1'b0, m};
      if (t >= {1'b0, m}) begin
         return d[WIDTH-1:0];
      end else begin
         return t[WIDTH-1:0];
      end
   endfunction

   // (a + b) mod m for a, b below m
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return reduce_once(s, m);
   endfunction

endpackage

### sv/elg_reduce.sv
module elg_reduce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [elg_pkg::WIDTH-1:0] x,
   input  logic [elg_pkg::WIDTH-1:0] modulus,
   output logic                      done,
   output logic [elg_pkg::WIDTH-1:0] result
);
   import elg_pkg::*;

   logic             run_ff, run_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] r_ff, r_in;

   assign done   = run_ff && (cnt_ff == '0);
   assign result = r_ff;

   // restoring remainder, one dividend bit per cycle, MSB first
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      x_in   = x_ff;
      r_in   = r_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(WIDTH);
         x_in   = x;
         r_in   = '0;
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            run_in = 1'b0;
         end else begin
            r_in   = reduce_once({r_ff, x_ff[WIDTH-1]}, modulus);
            x_in   = {x_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      r_ff <= r_in;
   end

endmodule

### sv/elg_mulmod.sv
module elg_mulmod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [elg_pkg::WIDTH-1:0] mcand,
   input  logic [elg_pkg::WIDTH-1:0] mplier,
   input  logic [elg_pkg::WIDTH-1:0] modulus,
   output logic                      done,
   output logic [elg_pkg::WIDTH-1:0] result
);
   import elg_pkg::*;

   logic             run_ff, run_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] u_ff, u_in;
   logic [WIDTH-1:0] v_ff, v_in;

   assign done   = run_ff && (v_ff == '0);
   assign result = acc_ff;

   // add-and-double, multiplier bits LSB first; stop once no bits remain
   always_comb begin
      run_in = run_ff;
      acc_in = acc_ff;
      u_in   = u_ff;
      v_in   = v_ff;
      if (start) begin
         run_in = 1'b1;
         acc_in = '0;
         u_in   = mcand;
         v_in   = mplier;
      end else if (run_ff) begin
         if (v_ff == '0) begin
            run_in = 1'b0;
         end else begin
            if (v_ff[0]) begin
               acc_in = add_mod(acc_ff, u_ff, modulus);
            end
            u_in = add_mod(u_ff, u_ff, modulus);
            v_in = {1'b0, v_ff[WIDTH-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
   end

endmodule

### sv/elgamal_cipher_core.sv
// Work: one operand reduction each (three for encrypt, two for decrypt) plus one
// bit-serial multiply per exponent bit, per set bit and a final one; when the modulus
// is below two the request skips all of these and goes straight to the response.
// Throughput: one request at a time; the next is taken as soon as the sequencer is idle,
// even while the previous response waits in the output register.
// Reset: synchronous, active high; modulus resets to 2, the other configuration registers to 1.
module elgamal_cipher_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [4*elg_pkg::WIDTH-1:0]   req_tdata,  // message, ephemeral_key, cipher_a, cipher_b
   input  logic                          req_tuser,  // mode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2*elg_pkg::WIDTH-1:0]   rsp_tdata,  // first_value, second_value
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [elg_pkg::IDX_W-1:0]     csr_index,
   input  logic [elg_pkg::WIDTH-1:0]     csr_data
);
   import elg_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_RED_OP   = 8'b0000_0010,
      S_RED_BASE = 8'b0000_0100,
      S_EXP_MUL  = 8'b0000_1000,
      S_EXP_SQR  = 8'b0001_0000,
      S_PASS_END = 8'b0010_0000,
      S_FIN_MUL  = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic             launch_ff, launch_in;
   logic             pass_ff, pass_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [WIDTH-1:0] modulus_ff, generator_ff, public_key_ff, private_key_ff;

   logic             mode_ff, mode_in;
   logic [WIDTH-1:0] opsrc_ff, opsrc_in;
   logic [WIDTH-1:0] basesrc_ff, basesrc_in;
   logic [WIDTH-1:0] key_ff, key_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] op_ff, op_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [WIDTH-1:0] first_ff, first_in;
   logic [WIDTH-1:0] second_ff, second_in;
   logic [WIDTH-1:0] rsp_first_ff, rsp_first_in;
   logic [WIDTH-1:0] rsp_second_ff, rsp_second_in;

   logic             red_start, red_done;
   logic [WIDTH-1:0] red_x, red_result;
   logic             mul_start, mul_done;
   logic [WIDTH-1:0] mul_u, mul_v, mul_result;

   logic             req_fire;
   logic             out_free;
   logic [WIDTH-1:0] exp_shift;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_second_ff, rsp_first_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign exp_shift  = {1'b0, exp_ff[WIDTH-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= WIDTH'(2);
         generator_ff   <= WIDTH'(1);
         public_key_ff  <= WIDTH'(1);
         private_key_ff <= WIDTH'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODULUS:     modulus_ff     <= csr_data;
            REG_GENERATOR:   generator_ff   <= csr_data;
            REG_PUBLIC_KEY:  public_key_ff  <= csr_data;
            REG_PRIVATE_KEY: private_key_ff <= csr_data;
            default: ;
         endcase
      end
   end

   elg_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .x       (red_x),
      .modulus (modulus_ff),
      .done    (red_done),
      .result  (red_result)
   );

   elg_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_u),
      .mplier  (mul_v),
      .modulus (modulus_ff),
      .done    (mul_done),
      .result  (mul_result)
   );

   always_comb begin
      red_x = opsrc_ff;
      if (state_ff == S_RED_BASE) begin
         if (mode_ff == MODE_DECRYPT) begin
            red_x = basesrc_ff;
         end else if (pass_ff) begin
            red_x = public_key_ff;
         end else begin
            red_x = generator_ff;
         end
      end
   end

   always_comb begin
      mul_u = res_ff;
      mul_v = base_ff;
      if (state_ff == S_EXP_SQR) begin
         mul_u = base_ff;
      end else if (state_ff == S_FIN_MUL) begin
         mul_v = op_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      launch_in     = launch_ff;
      pass_in       = pass_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      opsrc_in      = opsrc_ff;
      basesrc_in    = basesrc_ff;
      key_in        = key_ff;
      exp_in        = exp_ff;
      op_in         = op_ff;
      base_in       = base_ff;
      res_in        = res_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      red_start     = 1'b0;
      mul_start     = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in    = req_tuser;
               pass_in    = 1'b0;
               launch_in  = 1'b0;
               basesrc_in = req_tdata[3*WIDTH-1:2*WIDTH];
               first_in   = '0;
               second_in  = '0;
               if (req_tuser == MODE_DECRYPT) begin
                  opsrc_in = req_tdata[4*WIDTH-1:3*WIDTH];
                  key_in   = modulus_ff - WIDTH'(1) - private_key_ff;
               end else begin
                  opsrc_in = req_tdata[WIDTH-1:0];
                  key_in   = req_tdata[2*WIDTH-1:WIDTH];
               end
               if (modulus_ff < WIDTH'(2)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_RED_OP;
               end
            end
         end
         S_RED_OP: begin
            if (!launch_ff) begin
               red_start = 1'b1;
               launch_in = 1'b1;
            end else if (red_done) begin
               op_in     = red_result;
               launch_in = 1'b0;
               state_in  = S_RED_BASE;
            end
         end
         S_RED_BASE: begin
            if (!launch_ff) begin
               red_start = 1'b1;
               launch_in = 1'b1;
            end else if (red_done) begin
               base_in   = red_result;
               res_in    = WIDTH'(1);
               exp_in    = key_ff;
               launch_in = 1'b0;
               if (key_ff == '0) begin
                  state_in = S_PASS_END;
               end else if (key_ff[0]) begin
                  state_in = S_EXP_MUL;
               end else begin
                  state_in = S_EXP_SQR;
               end
            end
         end
         S_EXP_MUL: begin
            if (!launch_ff) begin
               mul_start = 1'b1;
               launch_in = 1'b1;
            end else if (mul_done) begin
               res_in    = mul_result;
               launch_in = 1'b0;
               state_in  = S_EXP_SQR;
            end
         end
         S_EXP_SQR: begin
            if (!launch_ff) begin
               mul_start = 1'b1;
               launch_in = 1'b1;
            end else if (mul_done) begin
               base_in   = mul_result;
               exp_in    = exp_shift;
               launch_in = 1'b0;
               if (exp_shift == '0) begin
                  state_in = S_PASS_END;
               end else if (exp_shift[0]) begin
                  state_in = S_EXP_MUL;
               end else begin
                  state_in = S_EXP_SQR;
               end
            end
         end
         S_PASS_END: begin
            // encrypt runs a second exponentiation with the public key
            if (mode_ff == MODE_ENCRYPT && !pass_ff) begin
               first_in = res_ff;
               pass_in  = 1'b1;
               state_in = S_RED_BASE;
            end else begin
               state_in = S_FIN_MUL;
            end
         end
         S_FIN_MUL: begin
            if (!launch_ff) begin
               mul_start = 1'b1;
               launch_in = 1'b1;
            end else if (mul_done) begin
               launch_in = 1'b0;
               if (mode_ff == MODE_DECRYPT) begin
                  first_in  = mul_result;
                  second_in = '0;
               end else begin
                  second_in = mul_result;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_first_in  = first_ff;
               rsp_second_in = second_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      opsrc_ff      <= opsrc_in;
      basesrc_ff    <= basesrc_in;
      key_ff        <= key_in;
      exp_ff        <= exp_in;
      op_ff         <= op_in;
      base_ff       <= base_in;
      res_ff        <= res_in;
      first_ff      <= first_in;
      second_ff     <= second_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

endmodule
